>>> hdl/rgbc_pkg.sv
// Package for the RGBC color classifier with automatic gain stepping.
// Holds the payload structs, the configuration bundle, register indexes and class codes.
// No dependencies.
`default_nettype none

package rgbc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned GainWidth  = 2;
  localparam int unsigned ClassWidth = 4;
  localparam int unsigned RegIdxWidth = 3;
  // Widest product: 1000 * 16-bit count
  localparam int unsigned ProdWidth  = 26;

  typedef logic [CountWidth-1:0]  count_t;
  typedef logic [GainWidth-1:0]   gain_t;
  typedef logic [RegIdxWidth-1:0] reg_idx_t;
  typedef logic [ProdWidth-1:0]   prod_t;

  localparam gain_t GainReset = 2'd2;
  localparam gain_t GainMax   = 2'd3;
  localparam gain_t GainMin   = 2'd0;

  localparam reg_idx_t REG_DARK_LIMIT       = 3'd0;
  localparam reg_idx_t REG_SATURATION_LIMIT = 3'd1;
  localparam reg_idx_t REG_GAIN_DOWN_LIMIT  = 3'd2;
  localparam reg_idx_t REG_GAIN_UP_LIMIT    = 3'd3;
  localparam reg_idx_t REG_PINK_MIN_CLEAR   = 3'd4;
  localparam reg_idx_t REG_WHITE_MIN_CLEAR  = 3'd5;
  localparam reg_idx_t REG_GRAY_MIN_CLEAR   = 3'd6;

  typedef enum logic [ClassWidth-1:0] {
    CLS_DARK      = 4'd0,
    CLS_SATURATED = 4'd1,
    CLS_PINK      = 4'd2,
    CLS_ORANGE    = 4'd3,
    CLS_MAGENTA   = 4'd4,
    CLS_RED       = 4'd5,
    CLS_YELLOW    = 4'd6,
    CLS_CYAN      = 4'd7,
    CLS_GREEN     = 4'd8,
    CLS_BLUE      = 4'd9,
    CLS_WHITE     = 4'd10,
    CLS_GRAY      = 4'd11,
    CLS_DARK_RED  = 4'd12,
    CLS_MIXED     = 4'd13
  } color_class_t;

  typedef struct packed {
    count_t red_count;
    count_t green_count;
    count_t blue_count;
    count_t clear_count;
  } in_item_t;

  typedef struct packed {
    gain_t                 gain_level;
    logic                  gain_changed;
    logic [ClassWidth-1:0] color_class;
  } out_item_t;

  typedef struct packed {
    count_t dark_limit;
    count_t saturation_limit;
    count_t gain_down_limit;
    count_t gain_up_limit;
    count_t pink_min_clear;
    count_t white_min_clear;
    count_t gray_min_clear;
  } cfg_regs_t;

  // Constant times a count, at product width.
  function automatic prod_t kmul(input int unsigned k, input count_t x);
    return prod_t'(k) * prod_t'(x);
  endfunction

endpackage

`default_nettype wire

>>> hdl/rgbc_classify.sv
// Color rule chain: turns one RGBC reading into a color class.
// Combinational; all ratio tests are exact cross-multiplied integer compares.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_classify
  import rgbc_pkg::*;
(
  input  in_item_t     item,
  input  cfg_regs_t    cfg,
  output color_class_t color_class
);

  count_t r, g, b, c;
  count_t mx, mn, d;
  logic   sat, near, similar_rg;

  assign r = item.red_count;
  assign g = item.green_count;
  assign b = item.blue_count;
  assign c = item.clear_count;

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  assign d          = mx - mn;
  assign sat        = kmul(50, d) > prod_t'(c);
  assign near       = kmul(500, d) < prod_t'(c);
  assign similar_rg = (kmul(100, r) > kmul(85, g)) && (kmul(100, r) < kmul(115, g));

  always_comb begin
    if (c < cfg.dark_limit) begin
      color_class = CLS_DARK;
    end else if (c > cfg.saturation_limit) begin
      color_class = CLS_SATURATED;
    end else if (c == '0) begin
      color_class = CLS_MIXED;
    end else if (r > g && r > b && sat && kmul(25, d) < kmul(2, c)
                 && c > cfg.pink_min_clear) begin
      color_class = CLS_PINK;
    end else if (r > g && r > b && sat && kmul(100, r) > kmul(105, g)) begin
      // red branch resolves fully once red clearly leads green
      if (kmul(10, g) > kmul(13, b))
        color_class = CLS_ORANGE;
      else if (kmul(5, b) > kmul(6, g))
        color_class = CLS_MAGENTA;
      else if (kmul(100, g) > kmul(105, b) && kmul(4, g) > kmul(3, r))
        color_class = CLS_PINK;
      else
        color_class = CLS_RED;
    end else if ((g >= r || similar_rg) && sat && similar_rg
                 && kmul(10, r) > kmul(13, b) && kmul(10, g) > kmul(13, b)) begin
      color_class = CLS_YELLOW;
    end else if (g > r && g > b && sat && kmul(100, g) > kmul(105, r)
                 && kmul(100, g) > kmul(105, b)) begin
      color_class = (kmul(10, b) > kmul(13, r)) ? CLS_CYAN : CLS_GREEN;
    end else if (b > r && b > g && sat && kmul(100, b) > kmul(105, r)
                 && kmul(100, b) > kmul(105, g)) begin
      if (kmul(10, r) > kmul(13, g))
        color_class = CLS_MAGENTA;
      else if (kmul(10, g) > kmul(13, r))
        color_class = CLS_CYAN;
      else
        color_class = CLS_BLUE;
    end else if (kmul(1000, d) < kmul(15, c) && kmul(100, r) > kmul(28, c)
                 && kmul(100, g) > kmul(28, c) && kmul(100, b) > kmul(28, c)
                 && c > cfg.white_min_clear) begin
      color_class = CLS_WHITE;
    end else if (near && kmul(100, r) > kmul(12, c) && kmul(100, r) < kmul(28, c)
                 && c > cfg.gray_min_clear && c < cfg.white_min_clear) begin
      color_class = CLS_GRAY;
    end else if (!near && r > b && kmul(100, r) >= kmul(95, g)) begin
      color_class = CLS_DARK_RED;
    end else begin
      color_class = CLS_MIXED;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rgbc_gain.sv
// Gain step register and its up/down decision.
// The step moves on each transfer into the result register.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_gain
  import rgbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  count_t    clear_count,
  input  cfg_regs_t cfg,
  output gain_t     gain_level,
  output logic      gain_changed
);

  gain_t gain_step;
  gain_t gain_step_next;
  logic  step_down, step_up;

  // stepping down wins over stepping up
  assign step_down = (clear_count > cfg.gain_down_limit) && (gain_step != GainMin);
  assign step_up   = (clear_count < cfg.gain_up_limit) && (gain_step != GainMax);

  always_comb begin
    if (step_down)
      gain_step_next = gain_step - gain_t'(1);
    else if (step_up)
      gain_step_next = gain_step + gain_t'(1);
    else
      gain_step_next = gain_step;
  end

  always_ff @(posedge clk) begin
    if (rst)
      gain_step <= GainReset;
    else if (advance)
      gain_step <= gain_step_next;
  end

  assign gain_level   = gain_step_next;
  assign gain_changed = step_down || step_up;

endmodule

`default_nettype wire

>>> hdl/rgbc_color_classifier_autogain_top.sv
// Top level of the RGBC color classifier with automatic gain stepping.
// Input register, gain step and color rules, result register, config registers.
// Depends on rgbc_pkg, rgbc_gain, rgbc_classify.
//
//  Channel | Signals                          | Payload
//  --------+----------------------------------+----------------------------
//  in      | in_valid, in_ready, in_item      | red/green/blue/clear counts
//  out     | out_valid, out_ready, out_item   | gain level, changed, class
//  cfg     | cfg_valid, cfg_ready, cfg_index  | cfg_data, 16-bit limit
//
// Two register stages, the input register and then the result register;
// one item per cycle is sustained while out_ready is high. Each stage holds
// while the stage after it is full and not taken, so a stalled output backs
// up to in_ready. cfg_ready is always high. Synchronous reset restores the
// limit registers and sets the gain step to GainReset (step 2).
`default_nettype none

module rgbc_color_classifier_autogain_top
  import rgbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  reg_idx_t  cfg_index,
  input  count_t    cfg_data
);

  cfg_regs_t    cfg;
  logic         s1_valid;
  in_item_t     s1_item;
  logic         advance;
  gain_t        gain_level;
  logic         gain_changed;
  color_class_t color_class;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_limit       <= 16'd50;
      cfg.saturation_limit <= 16'd60000;
      cfg.gain_down_limit  <= 16'd30000;
      cfg.gain_up_limit    <= 16'd2000;
      cfg.pink_min_clear   <= 16'd10000;
      cfg.white_min_clear  <= 16'd42000;
      cfg.gray_min_clear   <= 16'd2000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DARK_LIMIT:       cfg.dark_limit       <= cfg_data;
        REG_SATURATION_LIMIT: cfg.saturation_limit <= cfg_data;
        REG_GAIN_DOWN_LIMIT:  cfg.gain_down_limit  <= cfg_data;
        REG_GAIN_UP_LIMIT:    cfg.gain_up_limit    <= cfg_data;
        REG_PINK_MIN_CLEAR:   cfg.pink_min_clear   <= cfg_data;
        REG_WHITE_MIN_CLEAR:  cfg.white_min_clear  <= cfg_data;
        REG_GRAY_MIN_CLEAR:   cfg.gray_min_clear   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else if (in_valid && in_ready)
      s1_valid <= 1'b1;
    else if (advance)
      s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      s1_item <= in_item;
  end

  rgbc_gain u_gain (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .clear_count  (s1_item.clear_count),
    .cfg          (cfg),
    .gain_level   (gain_level),
    .gain_changed (gain_changed)
  );

  rgbc_classify u_classify (
    .item        (s1_item),
    .cfg         (cfg),
    .color_class (color_class)
  );

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (advance)
      out_valid <= 1'b1;
    else if (out_ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.gain_level   <= gain_level;
      out_item.gain_changed <= gain_changed;
      // class reads as dark when the gain stepped
      out_item.color_class  <= gain_changed ? CLS_DARK : color_class;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rgbc_checker.sv
// Port-level checker for the RGBC color classifier, bound to the top level.
// Watches result contents and output handshake over time.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_checker
  import rgbc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.gain_changed |-> out_item.color_class == CLS_DARK)
    else $error("class given with gain step");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.color_class <= CLS_MIXED)
    else $error("class code out of range");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a result only appears after some input transfer
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 1))
    else $error("result without input transfer");

endmodule

bind rgbc_color_classifier_autogain_top rgbc_checker u_rgbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
